/* rtl/otb_pkg.sv */
// ----------------------------------------------------------------------------
// otb_pkg
// Shared constants and payload types of the call-trace ring buffer.
// ----------------------------------------------------------------------------
package otb_pkg;

  localparam int DEPTH  = 2048;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = PTR_W + 1;
  localparam int ADDR_W = 64;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(2000);
  localparam logic [CNT_W-1:0] CAP_MIN   = CNT_W'(2);
  localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(DEPTH);

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [1:0] ENTRY_START = 2'd0;
  localparam logic [1:0] ENTRY_ENTER = 2'd1;
  localparam logic [1:0] ENTRY_EXIT  = 2'd2;

  typedef struct packed {
    logic [1:0]        entry_type;
    logic [ADDR_W-1:0] func_addr;
    logic [ADDR_W-1:0] call_addr;
  } entry_t;

  typedef struct packed {
    logic              kind;
    logic [1:0]        entry_type;
    logic [ADDR_W-1:0] func_addr;
    logic [ADDR_W-1:0] call_addr;
    logic [PTR_W-1:0]  read_index;
  } req_t;

  typedef struct packed {
    logic              read_valid;
    logic [1:0]        out_type;
    logic [ADDR_W-1:0] out_func_addr;
    logic [ADDR_W-1:0] out_call_addr;
    logic [CNT_W-1:0]  entry_count;
  } rsp_t;

endpackage

/* rtl/otb_if.sv */
// ----------------------------------------------------------------------------
// otb_if
// Valid/ready channels of the trace buffer: requests, results, configuration.
// ----------------------------------------------------------------------------
interface otb_req_if;
  import otb_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface otb_rsp_if;
  import otb_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface otb_cfg_if;
  import otb_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/overwrite_ring_trace_buffer.sv */
// ----------------------------------------------------------------------------
// overwrite_ring_trace_buffer
// Circular call-trace recorder that overwrites its oldest entry when full.
// ----------------------------------------------------------------------------
// The req channel carries one transaction per item: a record (type code,
// function and call-site address) or a read by logical index counted from
// the oldest entry. Each item gives exactly one transaction on rsp, holding
// the entry read (zero for records and misses), a valid flag and the entry
// count after the item. The cfg channel writes the capacity and is always
// ready; the user must write it only while the block is idle, which the
// block does not enforce. An item's result is registered on rsp at the edge
// that accepts it. One item is accepted per cycle while rsp does not stall;
// the figure is set by the single write or read port of the entry store and
// the one result register behind it. When rsp stalls, the result is held
// and req.ready stays low until the result is taken. Reset clears the oldest
// pointer and flags, sets the newest pointer to all ones and loads a
// capacity of 2000; the entry store itself is not cleared. The first record
// after reset also places a log-start entry, held as a flag on slot zero.
// ----------------------------------------------------------------------------
module overwrite_ring_trace_buffer (
  input logic      clk,
  input logic      rst,
  otb_cfg_if.sink  cfg,
  otb_req_if.sink  req,
  otb_rsp_if.source rsp
);
  import otb_pkg::*;

  logic [CNT_W-1:0] capacity;
  logic [CNT_W-1:0] cap_use;
  logic             started, started_next;
  logic             marker, marker_next;
  logic [PTR_W-1:0] oldest_ptr, oldest_ptr_next;
  logic [PTR_W-1:0] newest_ptr, newest_ptr_next;

  entry_t           store [DEPTH];
  entry_t           rd_entry;
  entry_t           wr_entry;
  logic             we;
  logic [PTR_W-1:0] wr_addr;
  logic [PTR_W-1:0] rd_addr;

  logic             rsp_valid;
  logic             rsp_hit, rsp_hit_next;
  logic             rsp_marker, rsp_marker_next;
  logic [CNT_W-1:0] rsp_count;
  logic [CNT_W-1:0] cnt_now;
  logic [CNT_W-1:0] cnt_next;
  logic [CNT_W-1:0] upper;
  logic [CNT_W-1:0] n_ext;
  logic [CNT_W-1:0] o_ext;
  logic [CNT_W-1:0] idx_ext;
  logic [PTR_W-1:0] n_ptr;
  logic [PTR_W-1:0] o_wrap;
  logic             accept;

  function automatic logic [CNT_W-1:0] held_count(
    input logic             st,
    input logic [PTR_W-1:0] oldest,
    input logic [PTR_W-1:0] newest,
    input logic [CNT_W-1:0] cap
  );
    logic [CNT_W-1:0] o_e;
    logic [CNT_W-1:0] n_e;
    logic [CNT_W-1:0] up;
    o_e = {1'b0, oldest};
    n_e = {1'b0, newest};
    up  = (o_e < cap) ? cap - o_e : '0;
    if (!st) begin
      return '0;
    end else if (n_e >= o_e) begin
      return n_e - o_e + CNT_W'(1);
    end else begin
      return up + n_e + CNT_W'(1);
    end
  endfunction

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg.valid) begin
      capacity <= cfg.data;
    end
  end

  always_comb begin
    if (capacity < CAP_MIN) begin
      cap_use = CAP_MIN;
    end else if (capacity > CAP_MAX) begin
      cap_use = CAP_MAX;
    end else begin
      cap_use = capacity;
    end
  end

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign n_ext   = {1'b0, newest_ptr} + CNT_W'(1);
  assign o_ext   = {1'b0, oldest_ptr} + CNT_W'(1);
  assign n_ptr   = (n_ext >= cap_use) ? '0 : n_ext[PTR_W-1:0];
  assign o_wrap  = (o_ext >= cap_use) ? '0 : o_ext[PTR_W-1:0];
  assign idx_ext = {1'b0, req.data.read_index};
  assign upper   = ({1'b0, oldest_ptr} < cap_use) ? cap_use - {1'b0, oldest_ptr} : '0;
  assign cnt_now = held_count(started, oldest_ptr, newest_ptr, cap_use);

  assign wr_entry.entry_type = req.data.entry_type;
  assign wr_entry.func_addr  = req.data.func_addr;
  assign wr_entry.call_addr  = req.data.call_addr;

  always_comb begin
    started_next    = started;
    marker_next     = marker;
    oldest_ptr_next = oldest_ptr;
    newest_ptr_next = newest_ptr;
    we              = 1'b0;
    wr_addr         = n_ptr;
    rd_addr         = oldest_ptr + req.data.read_index;
    rsp_hit_next    = 1'b0;
    rsp_marker_next = 1'b0;
    if (accept) begin
      unique case (req.data.kind)
        KIND_RECORD: begin
          we = 1'b1;
          if (!started) begin
            started_next    = 1'b1;
            marker_next     = 1'b1;
            oldest_ptr_next = '0;
            newest_ptr_next = PTR_W'(1);
            wr_addr         = PTR_W'(1);
          end else begin
            newest_ptr_next = n_ptr;
            if (oldest_ptr == n_ptr) begin
              oldest_ptr_next = o_wrap;
            end
            if (n_ptr == '0) begin
              marker_next = 1'b0;
            end
          end
        end
        KIND_READ: begin
          if (newest_ptr < oldest_ptr) begin
            if (idx_ext >= upper) begin
              rd_addr = PTR_W'(idx_ext - upper);
            end
          end
          rsp_hit_next    = idx_ext < cnt_now;
          rsp_marker_next = marker && (rd_addr == '0);
        end
        default: begin
        end
      endcase
    end
  end

  assign cnt_next = held_count(started_next, oldest_ptr_next, newest_ptr_next, cap_use);

  always_ff @(posedge clk) begin
    if (we) begin
      store[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req.data.kind == KIND_READ) begin
      rd_entry <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started    <= 1'b0;
      marker     <= 1'b0;
      oldest_ptr <= '0;
      newest_ptr <= '1;
      rsp_valid  <= 1'b0;
    end else begin
      started    <= started_next;
      marker     <= marker_next;
      oldest_ptr <= oldest_ptr_next;
      newest_ptr <= newest_ptr_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_hit    <= rsp_hit_next;
      rsp_marker <= rsp_marker_next;
      rsp_count  <= cnt_next;
    end
  end

  assign rsp.valid              = rsp_valid;
  assign rsp.data.read_valid    = rsp_hit;
  assign rsp.data.entry_count   = rsp_count;
  assign rsp.data.out_type      = (rsp_hit && !rsp_marker) ? rd_entry.entry_type : ENTRY_START;
  assign rsp.data.out_func_addr = (rsp_hit && !rsp_marker) ? rd_entry.func_addr : '0;
  assign rsp.data.out_call_addr = (rsp_hit && !rsp_marker) ? rd_entry.call_addr : '0;

  a_marker_needs_start: assert property (@(posedge clk) disable iff (rst)
    marker |-> started)
    else $error("log-start flag set before any record");

  a_record_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && req.data.kind == KIND_RECORD) |=> (started && rsp_count != '0))
    else $error("record left the buffer empty");

  a_read_keeps_ptrs: assert property (@(posedge clk) disable iff (rst)
    (accept && req.data.kind == KIND_READ) |=> ($stable(oldest_ptr) && $stable(newest_ptr)))
    else $error("read transaction moved a pointer");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_hit) |-> (rsp.data.out_type == ENTRY_START &&
                                 rsp.data.out_func_addr == '0 &&
                                 rsp.data.out_call_addr == '0))
    else $error("miss or record result carries entry data");

  a_empty_no_hit: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_count == '0) |-> !rsp_hit)
    else $error("read hit reported on an empty buffer");

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the overwrite-oldest call-trace ring buffer.
// ----------------------------------------------------------------------------
// Records and reads are driven on the request channel with random gaps.
// The result channel stalls at random. A scoreboard tracks the ring
// pointers, the capacity in use and the stored entries. It predicts one
// result per accepted request and compares it field by field. The capacity
// is changed between phases while the block is idle, out-of-range values
// included. Reads that would reach a slot never written are not generated.
// ----------------------------------------------------------------------------
module tb;
  import otb_pkg::*;

  class trace_scoreboard;
    logic [CNT_W-1:0]  cap_reg;
    bit                started;
    bit                empty;
    int unsigned       oldest;
    int unsigned       newest;
    logic [1:0]        type_mem [DEPTH];
    logic [ADDR_W-1:0] func_mem [DEPTH];
    logic [ADDR_W-1:0] call_mem [DEPTH];
    bit                written [DEPTH];
    rsp_t              pending_results [$];
    int                errors;
    int                records;
    int                reads;
    int                hits;
    int                overwrites;
    int                cap_writes;

    function new();
      cap_reg = CAP_RESET;
      started = 1'b0;
      empty = 1'b1;
      oldest = 0;
      newest = DEPTH - 1;
      foreach (written[i]) written[i] = 1'b0;
      errors = 0;
      records = 0;
      reads = 0;
      hits = 0;
      overwrites = 0;
      cap_writes = 0;
    endfunction

    function void write_capacity(logic [CNT_W-1:0] value);
      cap_reg = value;
      cap_writes++;
    endfunction

    function int unsigned cap_now();
      int unsigned c;
      c = cap_reg;
      if (c < CAP_MIN) c = CAP_MIN;
      if (c > CAP_MAX) c = CAP_MAX;
      return c;
    endfunction

    function int unsigned upper_len(int unsigned cap);
      return (oldest < cap) ? cap - oldest : 0;
    endfunction

    function int unsigned held();
      if (empty) return 0;
      if (newest >= oldest) return newest - oldest + 1;
      return upper_len(cap_now()) + newest + 1;
    endfunction

    function void place(logic [1:0] etype, logic [ADDR_W-1:0] fa, logic [ADDR_W-1:0] ca);
      int unsigned cap;
      int unsigned n;
      cap = cap_now();
      if (empty) begin
        oldest = 0;
        newest = 0;
        empty = 1'b0;
      end else begin
        n = newest + 1;
        if (n >= cap) n = 0;
        if (oldest == n) begin
          oldest++;
          if (oldest >= cap) oldest = 0;
          overwrites++;
        end
        newest = n;
      end
      type_mem[newest] = etype;
      func_mem[newest] = fa;
      call_mem[newest] = ca;
      written[newest] = 1'b1;
    endfunction

    function int unsigned slot_of(int unsigned idx);
      int unsigned up;
      if (newest >= oldest) return oldest + idx;
      up = upper_len(cap_now());
      return (idx < up) ? oldest + idx : idx - up;
    endfunction

    function bit read_safe(int unsigned idx);
      if (idx >= held()) return 1'b1;
      return written[slot_of(idx)];
    endfunction

    function void note_request(req_t r);
      rsp_t        e;
      int unsigned slot;
      e = '0;
      if (r.kind == KIND_RECORD) begin
        records++;
        if (!started) begin
          started = 1'b1;
          place(ENTRY_START, '0, '0);
        end
        place(r.entry_type, r.func_addr, r.call_addr);
      end else begin
        reads++;
        if (r.read_index < held()) begin
          slot = slot_of(r.read_index);
          e.read_valid = 1'b1;
          e.out_type = type_mem[slot];
          e.out_func_addr = func_mem[slot];
          e.out_call_addr = call_mem[slot];
          hits++;
        end
      end
      e.entry_count = CNT_W'(held());
      pending_results.push_back(e);
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: %h", got);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.read_valid !== exp.read_valid) begin
        $error("read_valid: expected %0d, got %0d", exp.read_valid, got.read_valid);
        errors++;
      end
      if (got.out_type !== exp.out_type) begin
        $error("out_type: expected %0d, got %0d", exp.out_type, got.out_type);
        errors++;
      end
      if (got.out_func_addr !== exp.out_func_addr) begin
        $error("out_func_addr: expected %h, got %h", exp.out_func_addr, got.out_func_addr);
        errors++;
      end
      if (got.out_call_addr !== exp.out_call_addr) begin
        $error("out_call_addr: expected %h, got %h", exp.out_call_addr, got.out_call_addr);
        errors++;
      end
      if (got.entry_count !== exp.entry_count) begin
        $error("entry_count: expected %0d, got %0d", exp.entry_count, got.entry_count);
        errors++;
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 2000;

  logic clk;
  logic rst;
  bit   calm;
  int   stall_left;
  int   idle_cycles;

  trace_scoreboard sb = new();

  otb_req_if req_ch ();
  otb_rsp_if rsp_ch ();
  otb_cfg_if cfg_ch ();

  overwrite_ring_trace_buffer dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99, 0);
    if (p < 80) return $urandom_range(3, 1);
    if (p < 95) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    int p;
    p = $urandom_range(19, 0);
    if (p == 0) return '0;
    if (p == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(req_t item);
    int gap;
    req_ch.valid <= 1'b1;
    req_ch.data <= item;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(item);
    @(negedge clk);
    gap = (!calm && $urandom_range(99, 0) < 30) ? gap_len() : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic record(logic [1:0] etype, logic [ADDR_W-1:0] fa, logic [ADDR_W-1:0] ca);
    req_t item;
    item.kind = KIND_RECORD;
    item.entry_type = etype;
    item.func_addr = fa;
    item.call_addr = ca;
    item.read_index = PTR_W'($urandom);
    send_item(item);
  endtask

  task automatic read_at(int unsigned idx);
    req_t item;
    if (!sb.read_safe(idx)) return;
    item.kind = KIND_READ;
    item.entry_type = 2'($urandom);
    item.func_addr = rand_addr();
    item.call_addr = rand_addr();
    item.read_index = PTR_W'(idx);
    send_item(item);
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic set_capacity(logic [CNT_W-1:0] value);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_capacity(value);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_item();
    int unsigned cnt;
    int unsigned idx;
    bit          found;
    logic [1:0]  etype;
    found = 1'b0;
    if ($urandom_range(99, 0) >= 55) begin
      for (int t = 0; t < 8 && !found; t++) begin
        cnt = sb.held();
        if (cnt > 0 && $urandom_range(3, 0) != 0) idx = $urandom_range(cnt - 1, 0);
        else idx = $urandom_range(DEPTH - 1, 0);
        found = sb.read_safe(idx);
      end
    end
    if (found) begin
      read_at(idx);
    end else begin
      etype = ($urandom_range(9, 0) == 0) ? 2'($urandom) : 2'($urandom_range(2, 1));
      record(etype, rand_addr(), rand_addr());
    end
  endtask

  initial begin
    rsp_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(99, 0) < 15) begin
        stall_left = gap_len() - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.data);
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", idle_cycles);
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    logic [CNT_W-1:0] cap_plan [12];
    cap_plan = '{12'd2, 12'd3, 12'd7, 12'd4095, 12'd0, 12'd16,
                 12'd1, 12'd2048, 12'd100, 12'd5, 12'd2000, 12'd33};
    idle_cycles = 0;
    calm = 1'b0;
    rst = 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reads on the empty buffer, then the first record with its start marker.
    read_at(0);
    read_at(DEPTH - 1);
    record(ENTRY_ENTER, '1, '1);
    read_at(0);
    read_at(1);
    read_at(2);
    record(ENTRY_EXIT, '0, '0);
    record(2'd3, 64'hA5A5_5A5A_0F0F_F0F0, 64'h1234_5678_9ABC_DEF0);
    read_at(2);
    read_at(3);

    // Shrink below the pointers, wrap, then grow past the written slots.
    set_capacity(12'd2);
    read_at(3);
    record(ENTRY_ENTER, 64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000);
    read_at(0);
    read_at(1);
    record(ENTRY_EXIT, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
    record(ENTRY_ENTER, '1, '0);
    read_at(0);
    read_at(1);
    read_at(2);
    set_capacity(12'd4095);
    read_at(0);
    read_at(DEPTH - 1);
    record(ENTRY_EXIT, '0, '1);
    read_at(1);

    foreach (cap_plan[i]) begin
      set_capacity(cap_plan[i]);
      calm = (i == 5);
      for (int n = 0; n < 110; n++) begin
        random_item();
        if (i == 2 && n == 50) wait_idle();
      end
    end
    calm = 1'b0;

    req_ch.valid <= 1'b0;
    for (int w = 0; w < 500 && sb.pending_results.size() != 0; w++) @(negedge clk);
    repeat (5) @(negedge clk);
    if (sb.pending_results.size() != 0) begin
      $error("%0d results never arrived", sb.pending_results.size());
      sb.errors++;
    end

    $display("Ran %0d records and %0d reads (%0d hits), %0d oldest-entry overwrites,",
             sb.records, sb.reads, sb.hits, sb.overwrites);
    $display("over %0d capacity writes including saturated values.", sb.cap_writes);
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/otb_pkg.sv
rtl/otb_if.sv
rtl/overwrite_ring_trace_buffer.sv
bench/tb.sv
